// File: design/sfd_pkg.sv
// Shared types, constants and codes of the sync frame deframer.
package sfd_pkg;

    // Frame layout and CRC-16/Modbus constants
    localparam logic [7:0]  SYNC_FIRST   = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND  = 8'h5A;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam int          HEADER_BYTES = 8;
    localparam int          CRC_BYTES    = 2;
    localparam logic [15:0] LEN_CEILING  = 16'd65525;

    // Byte positions inside the header
    localparam logic [15:0] POS_SYNC1    = 16'd0;
    localparam logic [15:0] POS_SYNC2    = 16'd1;
    localparam logic [15:0] POS_VERSION  = 16'd2;
    localparam logic [15:0] POS_TYPE     = 16'd3;
    localparam logic [15:0] POS_SEQ_LO   = 16'd4;
    localparam logic [15:0] POS_SEQ_HI   = 16'd5;
    localparam logic [15:0] POS_LEN_LO   = 16'd6;
    localparam logic [15:0] POS_LEN_HI   = 16'd7;

    // Counter defaults and output width of the statistics fields
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int STAT_W            = 32;

    // Configuration register indexes
    localparam int          CFG_ADDR_W      = 1;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_VERSION = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_LEN = 1'b1;
    localparam logic [7:0]  CFG_VERSION_RST = 8'd1;
    localparam logic [15:0] CFG_MAX_LEN_RST = 16'd256;

    // Event codes of one result word
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_GOOD    = 2'd1,
        EV_CRC_ERR = 2'd2,
        EV_HDR_ERR = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0]  version;
        logic [15:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_event             event_res;
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic [15:0]        payload_index;
        logic [7:0]         frame_type;
        logic [15:0]        frame_sequence;
        logic [15:0]        frame_payload_len;
        logic [STAT_W-1:0]  good_frames;
        logic [STAT_W-1:0]  crc_errors;
        logic [STAT_W-1:0]  header_errors;
    } t_result;

endpackage

// File: design/sfd_crc_byte.sv
// CRC-16/Modbus update for one byte, unrolled into an XOR network.
module sfd_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] v;

    // Shift the reflected CRC eight times
    always_comb begin
        v = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ sfd_pkg::CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        o_crc = v;
    end

endmodule

// File: design/sfd_parser.sv
// Frame parser: byte position tracking, CRC check, counters and result register.
module sfd_parser #(
    parameter int COUNTER_WIDTH = sfd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  sfd_pkg::t_cfg    i_cfg,
    output logic             o_adv,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output sfd_pkg::t_result o_res
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held_type, n_held_type;
    logic [15:0] r_held_seq, n_held_seq;
    logic [15:0] r_held_len, n_held_len;
    logic [7:0]  r_held_ver, n_held_ver;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [COUNTER_WIDTH-1:0] r_good, n_good;
    logic [COUNTER_WIDTH-1:0] r_crc_errs, n_crc_errs;
    logic [COUNTER_WIDTH-1:0] r_hdr_errs, n_hdr_errs;
    logic             r_out_valid;
    sfd_pkg::t_result r_res, n_res;

    logic [15:0] crc_next;
    logic [15:0] len_full;
    logic [16:0] crc_start;
    logic [16:0] pos_wide;
    logic [15:0] crc_got;
    logic        load;

    sfd_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    // Advance when the result register is empty or being drained
    assign o_adv       = !r_out_valid || i_res_ready;
    assign load        = i_valid && o_adv;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    assign len_full  = {i_byte, r_held_len[7:0]};
    assign crc_start = 17'(sfd_pkg::HEADER_BYTES) + {1'b0, r_held_len};
    assign pos_wide  = {1'b0, r_pos};
    assign crc_got   = {i_byte, r_crc_lo};

    // Next state and result for the word in the input register
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_held_type = r_held_type;
        n_held_seq  = r_held_seq;
        n_held_len  = r_held_len;
        n_held_ver  = r_held_ver;
        n_crc_lo    = r_crc_lo;
        n_good      = r_good;
        n_crc_errs  = r_crc_errs;
        n_hdr_errs  = r_hdr_errs;
        n_res       = '0;
        n_res.event_res = sfd_pkg::EV_NONE;

        if (r_pos == sfd_pkg::POS_SYNC1) begin
            // Hunt for the first sync byte
            if (i_byte == sfd_pkg::SYNC_FIRST) begin
                n_pos = sfd_pkg::POS_SYNC2;
                n_crc = sfd_pkg::CRC_INIT;
            end
        end else if (r_pos == sfd_pkg::POS_SYNC2) begin
            if (i_byte == sfd_pkg::SYNC_SECOND) begin
                n_pos = sfd_pkg::POS_VERSION;
            end else begin
                n_pos = (i_byte == sfd_pkg::SYNC_FIRST) ? sfd_pkg::POS_SYNC2
                                                        : sfd_pkg::POS_SYNC1;
                n_crc = sfd_pkg::CRC_INIT;
            end
        end else if (r_pos < 16'(sfd_pkg::HEADER_BYTES)) begin
            // Capture header fields
            n_crc = crc_next;
            n_pos = r_pos + 16'd1;
            case (r_pos)
                sfd_pkg::POS_VERSION: n_held_ver = i_byte;
                sfd_pkg::POS_TYPE:    n_held_type = i_byte;
                sfd_pkg::POS_SEQ_LO:  n_held_seq = {r_held_seq[15:8], i_byte};
                sfd_pkg::POS_SEQ_HI:  n_held_seq = {i_byte, r_held_seq[7:0]};
                sfd_pkg::POS_LEN_LO:  n_held_len = {r_held_len[15:8], i_byte};
                default:              n_held_len = len_full;
            endcase
            // Check version and length on the last header byte
            if (r_pos == sfd_pkg::POS_LEN_HI) begin
                if (r_held_ver != i_cfg.version || len_full > i_cfg.max_len ||
                    len_full > sfd_pkg::LEN_CEILING) begin
                    n_hdr_errs = r_hdr_errs + COUNTER_WIDTH'(1);
                    n_res.event_res = sfd_pkg::EV_HDR_ERR;
                    n_pos = (i_byte == sfd_pkg::SYNC_FIRST) ? sfd_pkg::POS_SYNC2
                                                            : sfd_pkg::POS_SYNC1;
                    n_crc = sfd_pkg::CRC_INIT;
                end
            end
        end else if (pos_wide < crc_start) begin
            // Pass payload on tentatively
            n_crc = crc_next;
            n_pos = r_pos + 16'd1;
            n_res.payload_valid = 1'b1;
            n_res.payload_byte  = i_byte;
            n_res.payload_index = r_pos - 16'(sfd_pkg::HEADER_BYTES);
        end else if (pos_wide == crc_start) begin
            n_crc_lo = i_byte;
            n_pos    = r_pos + 16'd1;
        end else begin
            // Compare the received CRC and commit or discard
            if (crc_got != r_crc) begin
                n_crc_errs = r_crc_errs + COUNTER_WIDTH'(1);
                n_res.event_res = sfd_pkg::EV_CRC_ERR;
                n_pos = (i_byte == sfd_pkg::SYNC_FIRST) ? sfd_pkg::POS_SYNC2
                                                        : sfd_pkg::POS_SYNC1;
            end else begin
                n_good = r_good + COUNTER_WIDTH'(1);
                n_res.event_res         = sfd_pkg::EV_GOOD;
                n_res.frame_type        = r_held_type;
                n_res.frame_sequence    = r_held_seq;
                n_res.frame_payload_len = r_held_len;
                n_pos = sfd_pkg::POS_SYNC1;
            end
            n_crc = sfd_pkg::CRC_INIT;
        end

        n_res.good_frames   = sfd_pkg::STAT_W'(n_good);
        n_res.crc_errors    = sfd_pkg::STAT_W'(n_crc_errs);
        n_res.header_errors = sfd_pkg::STAT_W'(n_hdr_errs);
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= sfd_pkg::POS_SYNC1;
            r_crc       <= sfd_pkg::CRC_INIT;
            r_good      <= '0;
            r_crc_errs  <= '0;
            r_hdr_errs  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos      <= n_pos;
                r_crc      <= n_crc;
                r_good     <= n_good;
                r_crc_errs <= n_crc_errs;
                r_hdr_errs <= n_hdr_errs;
            end
            if (o_adv) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // Header fields and result word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_held_type <= n_held_type;
            r_held_seq  <= n_held_seq;
            r_held_len  <= n_held_len;
            r_held_ver  <= n_held_ver;
            r_crc_lo    <= n_crc_lo;
            r_res       <= n_res;
        end
    end

    // A frame event never carries a payload byte
    a_event_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.event_res != sfd_pkg::EV_NONE |-> !r_res.payload_valid)
        else $error("event word flagged as payload");

    // Payload index stays inside the announced length
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.payload_valid |-> r_res.payload_index < r_held_len)
        else $error("payload index beyond frame length");

    // Position never runs past the CRC high byte
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos >= 16'(sfd_pkg::HEADER_BYTES) |->
        {1'b0, r_pos} <= crc_start + 17'd1)
        else $error("byte position past end of frame");

    // Good frame counter moves only with an accepted frame
    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good != $past(r_good) |-> r_out_valid && r_res.event_res == sfd_pkg::EV_GOOD)
        else $error("good frame count moved without a frame event");

endmodule

// File: design/sync_frame_deframer_crc16_unit.sv
// Top level of the sync frame deframer with CRC-16/Modbus check.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  s_axis   | in        | tvalid/tready          | tdata[7:0] in_byte
//  m_axis   | out       | tvalid/tready          | tuser event + payload flag, tdata fields
//  cfg      | in        | i_cfg_we, no wait      | i_cfg_addr index, i_cfg_wdata value
//
// One word is taken per cycle while m_axis is not stalled; a result word passes the
// input register, then parser logic into the result register.
// Reset is synchronous and active low; it clears position, CRC, counters and
// valid flags and restores the configuration defaults.
// A stall on m_axis holds the result register and lets one more word wait in the
// input register before s_axis_tready drops.
module sync_frame_deframer_crc16_unit #(
    parameter int COUNTER_WIDTH = sfd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] event_res, [2] payload_valid
    output logic [2:0]                     m_axis_tuser,
    // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
    // [47:32] frame_sequence, [63:48] frame_payload_len, [95:64] good_frames,
    // [127:96] crc_errors, [159:128] header_errors
    output logic [159:0]                   m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    sfd_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             adv;
    logic             res_valid;
    sfd_pkg::t_result res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version <= sfd_pkg::CFG_VERSION_RST;
            r_cfg.max_len <= sfd_pkg::CFG_MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sfd_pkg::CFG_IDX_VERSION: r_cfg.version <= i_cfg_wdata[7:0];
                sfd_pkg::CFG_IDX_MAX_LEN: r_cfg.max_len <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register: accept while empty or while the parser takes its word
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfd_parser #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_adv       (adv),
        .o_res_valid (res_valid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // Pack the result word
    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = {res.payload_valid, res.event_res};
    assign m_axis_tdata  = {res.header_errors, res.crc_errors, res.good_frames,
                            res.frame_payload_len, res.frame_sequence, res.frame_type,
                            res.payload_index, res.payload_byte};

endmodule

// File: tb/tb_sync_frame_deframer_crc16_unit.sv
// Self-checking testbench for the sync frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb_sync_frame_deframer_crc16_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [1:0] event_res, [2] payload_valid
    logic [2:0]                     m_axis_tuser;
    // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
    // [47:32] frame_sequence, [63:48] frame_payload_len, [95:64] good_frames,
    // [127:96] crc_errors, [159:128] header_errors
    logic [159:0]                   m_axis_tdata;
    logic                           i_cfg_we      = 1'b0;
    logic [sfd_pkg::CFG_ADDR_W-1:0] i_cfg_addr    = sfd_pkg::CFG_IDX_VERSION;
    logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    // Deframer mirror: configuration and parser state
    logic [7:0]  cfg_version;
    logic [15:0] cfg_max_len;
    logic [15:0] p_pos;
    logic [15:0] p_crc;
    logic [7:0]  p_version;
    logic [7:0]  p_type;
    logic [7:0]  p_crc_lo;
    logic [15:0] p_seq;
    logic [15:0] p_len;
    logic [31:0] p_good;
    logic [31:0] p_crc_err;
    logic [31:0] p_hdr_err;

    sfd_pkg::t_result predicted_words[$];
    int unsigned fail_count   = 0;
    int unsigned tx_idle_pct  = 14;
    int unsigned rx_idle_pct  = 84;
    int unsigned bytes_sent   = 0;
    int unsigned stall_cycles = 0;

    sync_frame_deframer_crc16_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // CRC-16/Modbus, one byte, LSB first
    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ sfd_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void deframer_reset();
        cfg_version = sfd_pkg::CFG_VERSION_RST;
        cfg_max_len = sfd_pkg::CFG_MAX_LEN_RST;
        p_pos       = sfd_pkg::POS_SYNC1;
        p_crc       = sfd_pkg::CRC_INIT;
        p_version   = '0;
        p_type      = '0;
        p_crc_lo    = '0;
        p_seq       = '0;
        p_len       = '0;
        p_good      = '0;
        p_crc_err   = '0;
        p_hdr_err   = '0;
    endfunction

    // Drop back to hunting; a 0xA5 just seen already counts as the first sync byte
    function automatic void hunt_restart(input logic [7:0] b);
        p_pos = (b == sfd_pkg::SYNC_FIRST) ? sfd_pkg::POS_SYNC2 : sfd_pkg::POS_SYNC1;
        p_crc = sfd_pkg::CRC_INIT;
    endfunction

    // Advance the parser by one link byte and return the result word it causes
    function automatic sfd_pkg::t_result deframe_byte(input logic [7:0] b);
        sfd_pkg::t_result r;
        logic [16:0]      crc_at;
        r = '0;
        r.event_res = sfd_pkg::EV_NONE;
        if (p_pos == sfd_pkg::POS_SYNC1) begin
            if (b == sfd_pkg::SYNC_FIRST) begin
                p_pos = sfd_pkg::POS_SYNC2;
                p_crc = sfd_pkg::CRC_INIT;
            end
        end else if (p_pos == sfd_pkg::POS_SYNC2) begin
            if (b == sfd_pkg::SYNC_SECOND)
                p_pos = sfd_pkg::POS_VERSION;
            else
                hunt_restart(b);
        end else if (p_pos < sfd_pkg::HEADER_BYTES) begin
            p_crc = crc16_modbus(p_crc, b);
            case (p_pos)
                sfd_pkg::POS_VERSION: p_version = b;
                sfd_pkg::POS_TYPE: p_type = b;
                sfd_pkg::POS_SEQ_LO: p_seq[7:0] = b;
                sfd_pkg::POS_SEQ_HI: p_seq[15:8] = b;
                sfd_pkg::POS_LEN_LO: p_len[7:0] = b;
                default: p_len[15:8] = b;
            endcase
            p_pos = p_pos + 16'd1;
            // Header check uses the version register as it stands now
            if (p_pos == sfd_pkg::HEADER_BYTES && (p_version != cfg_version ||
                    p_len > cfg_max_len || p_len > sfd_pkg::LEN_CEILING)) begin
                p_hdr_err   = p_hdr_err + 32'd1;
                r.event_res = sfd_pkg::EV_HDR_ERR;
                hunt_restart(b);
            end
        end else begin
            crc_at = 17'(sfd_pkg::HEADER_BYTES) + {1'b0, p_len};
            if ({1'b0, p_pos} < crc_at) begin
                p_crc           = crc16_modbus(p_crc, b);
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = p_pos - 16'(sfd_pkg::HEADER_BYTES);
                p_pos           = p_pos + 16'd1;
            end else if ({1'b0, p_pos} == crc_at) begin
                p_crc_lo = b;
                p_pos    = p_pos + 16'd1;
            end else if ({b, p_crc_lo} != p_crc) begin
                p_crc_err   = p_crc_err + 32'd1;
                r.event_res = sfd_pkg::EV_CRC_ERR;
                hunt_restart(b);
            end else begin
                p_good              = p_good + 32'd1;
                r.event_res         = sfd_pkg::EV_GOOD;
                r.frame_type        = p_type;
                r.frame_sequence    = p_seq;
                r.frame_payload_len = p_len;
                p_pos               = sfd_pkg::POS_SYNC1;
                p_crc               = sfd_pkg::CRC_INIT;
            end
        end
        r.good_frames   = p_good;
        r.crc_errors    = p_crc_err;
        r.header_errors = p_hdr_err;
        return r;
    endfunction

    // Offer one byte, hold it until taken, then log its predicted result
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_words.push_back(deframe_byte(b));
        bytes_sent++;
    endtask

    // Stop offering and wait until every predicted word has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [sfd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = value;
        @(posedge i_clk);
        if (idx == sfd_pkg::CFG_IDX_VERSION)
            cfg_version = value[7:0];
        else
            cfg_max_len = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send a frame; a header the block will reject is sent without payload or CRC.
    // skip_first leaves out the leading 0xA5 when the block already holds it.
    task automatic send_frame(input bit skip_first, input logic [7:0] version,
                              input logic [7:0] ftype, input logic [15:0] seq,
                              input logic [15:0] len, input bit extreme_fill,
                              input bit bad_crc, input logic [7:0] bad_hi);
        logic [15:0] crc;
        logic [7:0]  hdr [6];
        logic [7:0]  b;
        crc = sfd_pkg::CRC_INIT;
        hdr = '{version, ftype, seq[7:0], seq[15:8], len[7:0], len[15:8]};
        if (!skip_first)
            send_byte(sfd_pkg::SYNC_FIRST);
        send_byte(sfd_pkg::SYNC_SECOND);
        for (int k = 0; k < 6; k++) begin
            send_byte(hdr[k]);
            crc = crc16_modbus(crc, hdr[k]);
        end
        if (version != cfg_version || len > cfg_max_len || len > sfd_pkg::LEN_CEILING)
            return;
        for (int k = 0; k < int'(len); k++) begin
            b = extreme_fill ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255));
            send_byte(b);
            crc = crc16_modbus(crc, b);
        end
        // Inverting the low byte guarantees a mismatch whatever the high byte is
        send_byte(bad_crc ? ~crc[7:0] : crc[7:0]);
        send_byte(bad_crc ? bad_hi : crc[15:8]);
    endtask

    // Hunting: stray bytes, wrong second sync, 0xA5 as wrong second sync, empty payload
    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sfd_pkg::SYNC_FIRST);
        send_byte(8'h00);
        send_byte(sfd_pkg::SYNC_FIRST);
        send_frame(0, sfd_pkg::CFG_VERSION_RST, 8'hFF, 16'hFFFF, 16'd0, 0, 0, 8'h00);
    endtask

    // Bad version, then a length over the limit whose high byte 0xA5 restarts the hunt, then the frame after it
    task automatic test_header_errors();
        send_frame(0, 8'h00, 8'h12, 16'h3456, 16'd0, 0, 0, 8'h00);
        send_frame(0, sfd_pkg::CFG_VERSION_RST, 8'h01, 16'h0001, 16'hA500, 0, 0, 8'h00);
        send_frame(1, sfd_pkg::CFG_VERSION_RST, 8'h00, 16'h0000, 16'd2, 1, 0, 8'h00);
    endtask

    // Length above the frame ceiling is refused even when the register allows it
    task automatic test_length_ceiling();
        cfg_write(sfd_pkg::CFG_IDX_MAX_LEN, 16'hFFFF);
        send_frame(0, sfd_pkg::CFG_VERSION_RST, 8'h77, 16'h8001,
                   sfd_pkg::LEN_CEILING + 16'd1, 0, 0, 8'h00);
        cfg_write(sfd_pkg::CFG_IDX_MAX_LEN, sfd_pkg::CFG_MAX_LEN_RST);
    endtask

    // CRC mismatch ending in 0xA5, then the frame that follows it directly
    task automatic test_crc_error();
        send_frame(0, sfd_pkg::CFG_VERSION_RST, 8'h5A, 16'h00A5, 16'd1, 0, 1,
                   sfd_pkg::SYNC_FIRST);
        send_frame(1, sfd_pkg::CFG_VERSION_RST, 8'h80, 16'h7FFF, 16'd0, 0, 0, 8'h00);
    endtask

    // Mostly well-formed frames with random content, plus bad headers, broken frames, noise
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input logic [7:0] version, input logic [15:0] max_len,
                                       input int unsigned n_bytes, input bit pause_midway);
        int unsigned target;
        int unsigned pick;
        int unsigned cap;
        bit          paused;
        logic [15:0] len;
        logic [7:0]  ver;
        cfg_write(sfd_pkg::CFG_IDX_VERSION, {8'h00, version});
        cfg_write(sfd_pkg::CFG_IDX_MAX_LEN, max_len);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = bytes_sent + n_bytes;
        paused      = 0;
        cap         = (max_len < 16'd20) ? max_len : 20;
        while (bytes_sent < target) begin
            if (pause_midway && !paused && bytes_sent + n_bytes / 2 >= target) begin
                drain_results();
                paused = 1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = 16'($urandom_range(cap));
                if (pick < 2 && max_len <= 16'd300)
                    len = max_len;
                ver = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : version;
                send_frame(0, ver, 8'($urandom_range(255)), 16'($urandom_range(65535)), len,
                           0, $urandom_range(6) == 0, 8'($urandom_range(255)));
            end else if (pick < 80 && max_len < 16'hFFF0) begin
                len = max_len + 16'd1 + 16'($urandom_range(7));
                send_frame(0, version, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                           len, 0, 0, 8'h00);
            end else if (pick < 90) begin
                send_byte(sfd_pkg::SYNC_FIRST);
                send_byte(sfd_pkg::SYNC_SECOND);
                repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte($urandom_range(1) ? sfd_pkg::SYNC_FIRST
                                                : 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Compare each result word taken by the receiver with the oldest prediction
    always @(posedge i_clk) begin : result_check
        sfd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_words.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word, expected none, actual tuser 0x%0h tdata 0x%0h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = predicted_words.pop_front();
                check_field("event_res", want.event_res, m_axis_tuser[1:0]);
                check_field("payload_valid", want.payload_valid, m_axis_tuser[2]);
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("payload_index", want.payload_index, m_axis_tdata[23:8]);
                check_field("frame_type", want.frame_type, m_axis_tdata[31:24]);
                check_field("frame_sequence", want.frame_sequence, m_axis_tdata[47:32]);
                check_field("frame_payload_len", want.frame_payload_len, m_axis_tdata[63:48]);
                check_field("good_frames", want.good_frames, m_axis_tdata[95:64]);
                check_field("crc_errors", want.crc_errors, m_axis_tdata[127:96]);
                check_field("header_errors", want.header_errors, m_axis_tdata[159:128]);
            end
        end
    end

    // Abort when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        deframer_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sync_hunt();
        test_header_errors();
        test_length_ceiling();
        test_crc_error();
        test_random_traffic(14, 84, 8'hFF, 16'd40, 210, 0);
        test_random_traffic(84, 14, 8'h00, 16'd0, 210, 0);
        test_random_traffic(0, 0, 8'h01, 16'd300, 210, 1);

        drain_results();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
